### sv/nnd_pkg.sv
package nnd_pkg;

  // Register file layout
  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic [REG_W-1:0] RST_SRC_WIDTH  = 13'd1920;
  localparam logic [REG_W-1:0] RST_SRC_HEIGHT = 13'd1080;
  localparam logic [REG_W-1:0] RST_DST_WIDTH  = 13'd720;
  localparam logic [REG_W-1:0] RST_DST_HEIGHT = 13'd480;

  // Largest image dimension the counters are sized for
  localparam int NND_MAX_DIM = 4096;

  localparam int PIX_W = 8;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } pix_t;

endpackage

### sv/nearest_neighbor_downscaler.sv
// A selected pixel is written into the output buffer registers and then shown on out_valid.
// Throughput: one source pixel per cycle while not stalled; the select test and
// the walker update are adds and compares on the position sums, finished within
// the accept cycle. A two-entry output skid lets input continue while one
// result waits. Reset (rst_n low, synchronous) clears all counters and sums,
// empties the output buffer and loads the default sizes 1920x1080 to 720x480.
module nearest_neighbor_downscaler
  import nnd_pkg::*;
#(
  parameter int MAX_DIMENSION = NND_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_red_in,
  input  logic [PIX_W-1:0]     in_green_in,
  input  logic [PIX_W-1:0]     in_blue_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_red_out,
  output logic [PIX_W-1:0]     out_green_out,
  output logic [PIX_W-1:0]     out_blue_out,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_DIMENSION + 1);

  logic [CNT_W-1:0] src_w;
  logic [CNT_W-1:0] src_h;
  logic [CNT_W-1:0] dst_w;
  logic [CNT_W-1:0] dst_h;
  logic             accept;
  logic             hit;
  logic             frame_end;
  logic             full;
  pix_t             push_pix;
  pix_t             out_pix;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  nnd_cfg #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .src_w    (src_w),
    .src_h    (src_h),
    .dst_w    (dst_w),
    .dst_h    (dst_h)
  );

  nnd_walk #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .src_w     (src_w),
    .src_h     (src_h),
    .dst_w     (dst_w),
    .dst_h     (dst_h),
    .hit       (hit),
    .frame_end (frame_end)
  );

  // Pack the accepted pixel with its end-of-frame flag
  assign push_pix.red       = in_red_in;
  assign push_pix.green     = in_green_in;
  assign push_pix.blue      = in_blue_in;
  assign push_pix.frame_end = frame_end;

  nnd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && hit),
    .push_pix  (push_pix),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  assign out_red_out   = out_pix.red;
  assign out_green_out = out_pix.green;
  assign out_blue_out  = out_pix.blue;
  assign out_frame_end = out_pix.frame_end;

endmodule

### sv/nnd_cfg.sv
module nnd_cfg
  import nnd_pkg::*;
#(
  parameter int MAX_DIMENSION = NND_MAX_DIM,
  localparam int CNT_W = $clog2(MAX_DIMENSION + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output logic [CNT_W-1:0]     src_w,
  output logic [CNT_W-1:0]     src_h,
  output logic [CNT_W-1:0]     dst_w,
  output logic [CNT_W-1:0]     dst_h
);

  logic [REG_W-1:0] src_width_r;
  logic [REG_W-1:0] src_height_r;
  logic [REG_W-1:0] dst_width_r;
  logic [REG_W-1:0] dst_height_r;

  // Zero acts as one, values above the maximum act as the maximum
  function automatic logic [CNT_W-1:0] eff_dim(input logic [REG_W-1:0] v);
    logic [CNT_W-1:0] d;
    if (v == '0) begin
      d = CNT_W'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      d = CNT_W'(MAX_DIMENSION);
    end else begin
      d = CNT_W'(v);
    end
    return d;
  endfunction

  // Write one register per handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      dst_width_r  <= RST_DST_WIDTH;
      dst_height_r <= RST_DST_HEIGHT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SRC_WIDTH:  src_width_r  <= wr_data;
        REG_SRC_HEIGHT: src_height_r <= wr_data;
        REG_DST_WIDTH:  dst_width_r  <= wr_data;
        REG_DST_HEIGHT: dst_height_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign src_w = eff_dim(src_width_r);
  assign src_h = eff_dim(src_height_r);
  assign dst_w = eff_dim(dst_width_r);
  assign dst_h = eff_dim(dst_height_r);

endmodule

### sv/nnd_walk.sv
module nnd_walk
  import nnd_pkg::*;
#(
  parameter int MAX_DIMENSION = NND_MAX_DIM,
  localparam int CNT_W = $clog2(MAX_DIMENSION + 1),
  localparam int SUM_W = 2 * CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [CNT_W-1:0] src_w,
  input  logic [CNT_W-1:0] src_h,
  input  logic [CNT_W-1:0] dst_w,
  input  logic [CNT_W-1:0] dst_h,
  output logic             hit,
  output logic             frame_end
);

  logic [CNT_W-1:0] sx_r, sx_nxt;
  logic [CNT_W-1:0] sy_r, sy_nxt;
  logic [CNT_W-1:0] ox_r, ox_nxt;
  logic [CNT_W-1:0] oy_r, oy_nxt;
  logic [SUM_W-1:0] ctgt_r, ctgt_nxt;
  logic [SUM_W-1:0] cpos_r, cpos_nxt;
  logic [SUM_W-1:0] rtgt_r, rtgt_nxt;
  logic [SUM_W-1:0] rpos_r, rpos_nxt;

  logic [SUM_W:0] cpos_hi;
  logic [SUM_W:0] rpos_hi;
  logic           col_hit;
  logic           row_hit;
  logic           row_end;
  logic           frm_end;

  // Select test: position <= target < position + destination size
  assign cpos_hi = {1'b0, cpos_r} + (SUM_W + 1)'(dst_w);
  assign rpos_hi = {1'b0, rpos_r} + (SUM_W + 1)'(dst_h);

  assign col_hit = (ox_r < dst_w) && (cpos_r <= ctgt_r) &&
                   ({1'b0, ctgt_r} < cpos_hi);
  assign row_hit = (oy_r < dst_h) && (rpos_r <= rtgt_r) &&
                   ({1'b0, rtgt_r} < rpos_hi);

  assign hit       = col_hit && row_hit;
  assign frame_end = (ox_r == dst_w - CNT_W'(1)) && (oy_r == dst_h - CNT_W'(1));

  assign row_end = sx_r >= src_w - CNT_W'(1);
  assign frm_end = sy_r >= src_h - CNT_W'(1);

  // Advance the column and row walkers by one source pixel
  always_comb begin
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    ctgt_nxt = ctgt_r;
    cpos_nxt = cpos_r;
    rtgt_nxt = rtgt_r;
    rpos_nxt = rpos_r;
    if (step) begin
      if (hit) begin
        ox_nxt   = ox_r + CNT_W'(1);
        ctgt_nxt = ctgt_r + SUM_W'(src_w);
      end
      if (row_end) begin
        sx_nxt   = '0;
        ox_nxt   = '0;
        ctgt_nxt = '0;
        cpos_nxt = '0;
        if (frm_end) begin
          sy_nxt   = '0;
          oy_nxt   = '0;
          rtgt_nxt = '0;
          rpos_nxt = '0;
        end else begin
          if (row_hit) begin
            oy_nxt   = oy_r + CNT_W'(1);
            rtgt_nxt = rtgt_r + SUM_W'(src_h);
          end
          sy_nxt   = sy_r + CNT_W'(1);
          rpos_nxt = rpos_r + SUM_W'(dst_h);
        end
      end else begin
        sx_nxt   = sx_r + CNT_W'(1);
        cpos_nxt = cpos_r + SUM_W'(dst_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r   <= '0;
      sy_r   <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      ctgt_r <= '0;
      cpos_r <= '0;
      rtgt_r <= '0;
      rpos_r <= '0;
    end else begin
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      ctgt_r <= ctgt_nxt;
      cpos_r <= cpos_nxt;
      rtgt_r <= rtgt_nxt;
      rpos_r <= rpos_nxt;
    end
  end

endmodule

### sv/nnd_obuf.sv
module nnd_obuf
  import nnd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pix_t push_pix,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output pix_t out_pix
);

  pix_t       head_r, head_nxt;
  pix_t       tail_r, tail_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = count_r != 2'd0;
  assign full      = count_r == 2'd2;
  assign pop       = out_valid && !out_stall;
  assign out_pix   = head_r;

  // Two-entry skid: head drives the port, tail catches an item under stall
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt  = tail_r;
      count_nxt = count_r - 2'd1;
    end
    if (push) begin
      if (count_nxt == 2'd0) begin
        head_nxt = push_pix;
      end else begin
        tail_nxt = push_pix;
      end
      count_nxt = count_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

### sv/nnd_checker.sv
module nnd_checker
  import nnd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_red_out,
  input logic [PIX_W-1:0] out_green_out,
  input logic [PIX_W-1:0] out_blue_out,
  input logic             out_frame_end
);

  // Output buffer is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A result only appears after an accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without accepted item");

  // Input is held back only while results are waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out) && $stable(out_frame_end))
    else $error("stalled result changed");

endmodule

bind nearest_neighbor_downscaler nnd_checker u_nnd_checker (.*);
